// ----- rtl/sst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants and types for the sorted set table and its cells.
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int CAPACITY = 16;
   localparam int KEY_BITS = 32;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   typedef logic [KEY_BITS-1:0] key_type;

   // shift request broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } sst_op_type;

endpackage
`default_nettype wire

// ----- rtl/sst_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sst_cell
// One slot of the table: holds a key, compares it against the probe and
// shifts toward either neighbor.
// ----------------------------------------------------------------------------
module sst_cell (
   input  wire                  clock,
   input  wire                  occupied,
   input  wire                  probe_en,
   input  wire sst_pkg::key_type probe_key,
   input  wire sst_pkg::key_type load_key,
   input  wire sst_pkg::sst_op_type op,
   input  wire sst_pkg::key_type left_key,
   input  wire                  left_lt,
   input  wire sst_pkg::key_type right_key,
   output sst_pkg::key_type      key,
   output logic                  lt,
   output logic                  eq
);
   import sst_pkg::*;

   key_type key_ff, key_in;
   logic    lt_ff, lt_in;
   logic    eq_ff, eq_in;

   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (probe_en) begin
         lt_in = occupied & (key_ff < probe_key);
         eq_in = occupied & (key_ff == probe_key);
      end
   end

   always_comb begin
      key_in = key_ff;
      if (op.ins && !lt_ff) begin
         key_in = left_lt ? load_key : left_key;
      end else if (op.rem && !lt_ff) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key = key_ff;
   assign lt  = lt_ff;
   assign eq  = eq_ff;

endmodule
`default_nettype wire

// ----- rtl/sorted_set_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_table
// Bounded set of distinct signed keys kept in ascending order in a row of
// shifting cells. Insert, search and remove, one result per request.
//
//   channel  dir  ports                                        
//   req      in   req_valid req_stall req_command req_key
//   rsp      out  rsp_valid rsp_stall rsp_found rsp_position rsp_table_full
//
// Each beat takes a parallel compare in every cell, then the one-place shift
// of the cells at and above the rank.
// Reset empties the table; cell contents are not cleared.
// A stalled rsp beat holds the next request in its shift cycle; req_stall
// is high while a request is in flight.
// ----------------------------------------------------------------------------
module sorted_set_table (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [1:0]  req_command,
   input  wire signed [31:0] req_key,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_found,
   output logic [3:0] rsp_position,
   output logic       rsp_table_full
);
   import sst_pkg::*;

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       cmd_ff;
   key_type          probe_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff;
   logic [3:0]       position_ff;
   logic             full_ff;

   key_type          probe_key;
   logic             accept;
   logic             exec;
   logic             hit;
   logic             is_full;
   logic [IDX_W-1:0] rank;
   logic [IDX_W+3:0] rank_ext;
   sst_op_type       op;

   key_type          key_w [CAPACITY];
   logic [CAPACITY-1:0] lt_w;
   logic [CAPACITY-1:0] eq_w;
   logic [CAPACITY-1:0] occ_w;
   logic [CAPACITY-1:0] edge_w;

   // sign bit flipped so unsigned compare gives signed order
   always_comb begin
      probe_key = KEY_BITS'(req_key);
      probe_key[KEY_BITS-1] = ~probe_key[KEY_BITS-1];
   end

   assign req_stall = busy_ff;
   assign accept    = req_valid & ~busy_ff;
   assign exec      = busy_ff & (~rsp_valid_ff | ~rsp_stall);

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         assign occ_w[g] = (CNT_W'(g) < count_ff);
         if (g == 0) begin : g_first
            assign edge_w[g] = ~lt_w[g];
         end else begin : g_rest
            assign edge_w[g] = ~lt_w[g] & lt_w[g-1];
         end
         sst_cell u_cell (
            .clock     (clock),
            .occupied  (occ_w[g]),
            .probe_en  (accept),
            .probe_key (probe_key),
            .load_key  (probe_ff),
            .op        (op),
            .left_key  ((g == 0) ? probe_ff : key_w[(g == 0) ? 0 : g-1]),
            .left_lt   ((g == 0) ? 1'b1 : lt_w[(g == 0) ? 0 : g-1]),
            .right_key ((g == CAPACITY-1) ? probe_ff
                                          : key_w[(g == CAPACITY-1) ? g : g+1]),
            .key       (key_w[g]),
            .lt        (lt_w[g]),
            .eq        (eq_w[g])
         );
      end
   endgenerate

   always_comb begin
      rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (edge_w[i]) begin
            rank = rank | IDX_W'(i);
         end
      end
   end

   assign rank_ext = {4'b0, rank};
   assign hit      = |eq_w;
   assign is_full  = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      op.ins = exec & (cmd_ff == CMD_INSERT) & ~hit & ~is_full;
      op.rem = exec & (cmd_ff == CMD_REMOVE) & hit;
   end

   always_comb begin
      count_in = count_ff;
      if (op.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
      busy_in      = accept | (busy_ff & ~exec);
      rsp_valid_in = exec | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         probe_ff <= probe_key;
      end
      if (exec) begin
         found_ff    <= hit;
         position_ff <= (hit | op.ins) ? rank_ext[3:0] : 4'd0;
         full_ff     <= (cmd_ff == CMD_INSERT) & ~hit & is_full;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_position   = position_ff;
   assign rsp_table_full = full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("key count above capacity");

   a_search_stable: assert property (@(posedge clock) disable iff (reset)
      exec && (cmd_ff == CMD_SEARCH) |=> $stable(count_ff))
      else $error("search changed the table");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(found_ff && full_ff))
      else $error("dropped insert reported as found");

   a_no_exec_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && $stable(count_ff))
      else $error("accept did not start an operation");

endmodule
`default_nettype wire

// ----- verif/sorted_set_table_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_set_table_tb
// Self-checking bench for the sorted set table. A queue of insert, search and
// remove beats is built up front: a directed opening (empty, extreme keys,
// duplicates, full table, unused command) followed by random episodes drawn
// from small key pools so hits, fills and drains are frequent. A driver
// feeds the req channel with random gaps, a monitor stalls the rsp channel
// at random, and each rsp beat is checked against an in-bench model of the
// ordered set.
// ----------------------------------------------------------------------------
module sorted_set_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sst_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_OPS = 1850;
   localparam int CALM_LO = 800;
   localparam int CALM_HI = 1100;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 100;

   typedef struct {
      logic [1:0]                 command;
      logic signed [KEY_BITS-1:0] key;
      bit                         hold;
   } set_op_type;

   typedef struct {
      logic [1:0]                 command;
      logic signed [KEY_BITS-1:0] key;
      logic                       found;
      logic [3:0]                 position;
      logic                       table_full;
   } set_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = CMD_SEARCH;
   logic signed [31:0] req_key = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_found;
   logic [3:0]         rsp_position;
   logic               rsp_table_full;

   set_op_type    pending_ops[$];
   set_reply_type expected_replies[$];

   logic signed [KEY_BITS-1:0] set_keys [CAPACITY];
   int set_size = 0;

   int accepted_total = 0;
   int reply_count = 0;
   int errors = 0;
   int cycle_count = 0;
   int n_insert = 0;
   int n_search = 0;
   int n_remove = 0;
   int n_hit = 0;
   int n_drop = 0;

   sorted_set_table u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_position   (rsp_position),
      .rsp_table_full (rsp_table_full)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ordered-set model; updates set_keys/set_size and returns the reply
   function automatic set_reply_type apply_set_op(logic [1:0] cmd,
                                                  logic signed [KEY_BITS-1:0] key);
      set_reply_type r;
      int rank;
      bit hit;
      rank = 0;
      while (rank < set_size && set_keys[rank] < key)
         rank++;
      hit = (rank < set_size) && (set_keys[rank] == key);
      r.command = cmd;
      r.key = key;
      r.found = hit;
      r.position = '0;
      r.table_full = 1'b0;
      if (hit) begin
         r.position = 4'(rank);
         if (cmd == CMD_REMOVE) begin
            for (int i = rank; i + 1 < set_size; i++)
               set_keys[i] = set_keys[i + 1];
            set_size--;
         end
      end else if (cmd == CMD_INSERT) begin
         if (set_size >= CAPACITY) begin
            r.table_full = 1'b1;
         end else begin
            for (int i = set_size; i > rank; i--)
               set_keys[i] = set_keys[i - 1];
            set_keys[rank] = key;
            set_size++;
            r.position = 4'(rank);
         end
      end
      return r;
   endfunction

   function automatic logic signed [KEY_BITS-1:0] pick_key();
      logic signed [KEY_BITS-1:0] k;
      case ($urandom_range(3))
         0: k = $urandom;
         1: k = 32'($urandom_range(64)) - 32'd32;
         2: k = 32'sh8000_0000 + 32'($urandom_range(15));
         default: k = 32'sh7fff_ffff - 32'($urandom_range(15));
      endcase
      return k;
   endfunction

   task automatic add_op(logic [1:0] cmd, logic signed [KEY_BITS-1:0] key, bit hold);
      set_op_type op;
      op.command = cmd;
      op.key = key;
      op.hold = hold;
      pending_ops.push_back(op);
   endtask

   task automatic report_mismatch(string field, set_reply_type exp, int exp_val, int got_val);
      if (errors < MAX_REPORTS)
         $display("MISMATCH %s: cmd %0d key %0d expected %0d got %0d",
                  field, exp.command, exp.key, exp_val, got_val);
      errors++;
   endtask

   // req driver: one beat per free slot, random gaps outside the calm window
   always @(posedge clock) begin : driver
      set_op_type op;
      set_reply_type pred;
      bit gap;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pred = apply_set_op(req_command, req_key);
            expected_replies.push_back(pred);
            accepted_total++;
            case (req_command)
               CMD_INSERT: n_insert++;
               CMD_REMOVE: n_remove++;
               default:    n_search++;
            endcase
            if (pred.found)
               n_hit++;
            if (pred.table_full)
               n_drop++;
         end
         if (!req_valid || !req_stall) begin
            gap = !(accepted_total >= CALM_LO && accepted_total < CALM_HI) &&
                  ($urandom_range(99) < 21);
            if (!gap && pending_ops.size() != 0 &&
                !(pending_ops[0].hold && accepted_total != reply_count)) begin
               op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_command <= op.command;
               req_key <= op.key;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // rsp monitor
   always @(posedge clock) begin : monitor
      set_reply_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            exp.command = CMD_UNUSED;
            exp.key = '0;
            report_mismatch("unexpected beat", exp, 0, 1);
         end else begin
            exp = expected_replies.pop_front();
            if (rsp_found !== exp.found)
               report_mismatch("found", exp, exp.found, rsp_found);
            if (rsp_position !== exp.position)
               report_mismatch("position", exp, exp.position, rsp_position);
            if (rsp_table_full !== exp.table_full)
               report_mismatch("table_full", exp, exp.table_full, rsp_table_full);
         end
         reply_count <= reply_count + 1;
      end
      rsp_stall <= !(reply_count >= CALM_LO && reply_count < CALM_HI) &&
                   ($urandom_range(99) < 21);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, expected_replies.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      logic signed [KEY_BITS-1:0] pool[$];
      int added;
      int pool_n;
      int len;
      int mode;
      int roll;
      int total_ops;
      bit hold;
      logic [1:0] cmd;
      logic signed [KEY_BITS-1:0] key;

      // directed opening
      add_op(CMD_SEARCH, 32'sh8000_0000, 1'b0);
      add_op(CMD_REMOVE, 32'sh7fff_ffff, 1'b0);
      add_op(CMD_UNUSED, 32'sd0, 1'b0);
      add_op(CMD_INSERT, 32'sh8000_0000, 1'b0);
      add_op(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
      add_op(CMD_INSERT, 32'sh8000_0000, 1'b0);
      add_op(CMD_SEARCH, 32'sh7fff_ffff, 1'b0);
      add_op(CMD_REMOVE, 32'sh8000_0000, 1'b0);
      for (int i = 0; i < CAPACITY - 1; i++)
         add_op(CMD_INSERT, 32'(((i * 7) % 15) * 1000) - 32'sd7000, 1'b0);
      add_op(CMD_INSERT, 32'sd12345, 1'b1);
      add_op(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
      add_op(CMD_REMOVE, 32'sh7fff_ffff, 1'b0);

      // random episodes: fill, drain or mixed over a small key pool
      added = 0;
      while (added < RANDOM_OPS) begin
         pool.delete();
         pool_n = $urandom_range(4, 28);
         for (int i = 0; i < pool_n; i++)
            pool.push_back(pick_key());
         mode = $urandom_range(2);
         len = $urandom_range(20, 80);
         hold = (added == 0) || ($urandom_range(3) == 0);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 10) begin
               cmd = 2'($urandom_range(3));
               key = pick_key();
            end else begin
               roll = $urandom_range(99);
               case (mode)
                  0: cmd = (roll < 65) ? CMD_INSERT : (roll < 85) ? CMD_SEARCH : CMD_REMOVE;
                  1: cmd = (roll < 15) ? CMD_INSERT : (roll < 35) ? CMD_SEARCH : CMD_REMOVE;
                  default: cmd = (roll < 40) ? CMD_INSERT : (roll < 70) ? CMD_SEARCH : CMD_REMOVE;
               endcase
               key = pool[$urandom_range(pool_n - 1)];
            end
            add_op(cmd, key, hold && (i == 0));
            added++;
         end
      end
      total_ops = pending_ops.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (accepted_total != total_ops)
         @(posedge clock);
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d beats: %0d insert, %0d search, %0d remove", total_ops,
               n_insert, n_search, n_remove);
      $display("Key hits %0d, inserts dropped on a full table %0d, mismatches %0d",
               n_hit, n_drop, errors);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
